// ===== hdl/ubt_pkg.sv =====
// Shared types and constants for the unordered bag table.
// Holds operation codes, the engine state encoding and default sizes.
// Depends on nothing.
package ubt_pkg;

	localparam int DEFAULT_CAPACITY = 16;
	localparam int FUNC_W = 2;
	localparam int DATA_W = 32;

	localparam logic [FUNC_W-1:0] FUNC_ADD = 2'd0;
	localparam logic [FUNC_W-1:0] FUNC_REMOVE_ONE = 2'd1;
	localparam logic [FUNC_W-1:0] FUNC_REMOVE_ALL = 2'd2;

	typedef enum logic [4:0] {
		ST_IDLE = 5'b00001,
		ST_CMP  = 5'b00010,
		ST_MOVE = 5'b00100,
		ST_SCAN = 5'b01000,
		ST_DONE = 5'b10000
	} state_t;

endpackage

// ===== hdl/ubt_engine.sv =====
// Operation sequencer and entry memory for the unordered bag table.
// Scans, swaps and appends entries with read-modify-write on one memory.
// Depends on ubt_pkg.
module ubt_engine import ubt_pkg::*; #(
	parameter int CAPACITY = DEFAULT_CAPACITY,
	parameter int CW = $clog2(CAPACITY + 1),
	parameter int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     req_valid,
	output logic                     req_stall,
	input  logic [FUNC_W-1:0]        req_func,
	input  logic signed [DATA_W-1:0] req_value,
	output logic                     res_valid,
	input  logic                     res_ready,
	output logic                     res_success,
	output logic [CW-1:0]            res_removed,
	output logic [CW-1:0]            res_items
);

	logic [DATA_W-1:0] mem [CAPACITY];
	logic [DATA_W-1:0] rdata_q;
	logic [IW-1:0]     raddr;
	logic              we;

	state_t            state_q;
	logic [FUNC_W-1:0] func_q;
	logic [DATA_W-1:0] value_q;
	logic [IW-1:0]     idx_q;
	logic [CW-1:0]     fill_q;
	logic [CW-1:0]     gone_q;
	logic              ok_q;

	logic              accept;
	logic              match;
	logic [IW-1:0]     last_idx;
	logic [CW-1:0]     idx_next_w;
	logic [CW-1:0]     fill_dec;

	assign req_stall  = (state_q != ST_IDLE);
	assign accept     = req_valid && !req_stall;
	assign match      = (rdata_q == value_q);
	assign fill_dec   = fill_q - 1'b1;
	assign last_idx   = fill_dec[IW-1:0];
	assign idx_next_w = CW'(idx_q) + 1'b1;
	assign we         = (state_q == ST_MOVE);

	always_comb begin
		raddr = idx_q;
		unique case (state_q)
			ST_IDLE: raddr = '0;
			ST_CMP: begin
				if (match) begin
					raddr = last_idx;
				end else begin
					raddr = idx_next_w[IW-1:0];
				end
			end
			ST_MOVE, ST_SCAN, ST_DONE: raddr = idx_q;
			default: raddr = idx_q;
		endcase
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem[idx_q] <= rdata_q;
		end else if (accept && req_func == FUNC_ADD && fill_q < CW'(CAPACITY)) begin
			mem[fill_q[IW-1:0]] <= req_value;
		end
		rdata_q <= mem[raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			fill_q  <= '0;
			idx_q   <= '0;
			gone_q  <= '0;
			ok_q    <= 1'b0;
			func_q  <= FUNC_ADD;
			value_q <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						func_q  <= req_func;
						value_q <= req_value;
						idx_q   <= '0;
						gone_q  <= '0;
						ok_q    <= 1'b0;
						state_q <= ST_DONE;
						case (req_func)
							FUNC_ADD: begin
								if (fill_q < CW'(CAPACITY)) begin
									fill_q <= fill_q + 1'b1;
									ok_q   <= 1'b1;
								end
							end
							FUNC_REMOVE_ONE, FUNC_REMOVE_ALL: begin
								if (fill_q != '0) begin
									state_q <= ST_CMP;
								end
							end
							default: state_q <= ST_DONE;
						endcase
					end
				end
				ST_CMP: begin
					if (match) begin
						state_q <= ST_MOVE;
					end else if (idx_next_w < fill_q) begin
						idx_q <= idx_next_w[IW-1:0];
					end else begin
						state_q <= ST_DONE;
					end
				end
				ST_MOVE: begin
					fill_q <= fill_dec;
					gone_q <= gone_q + 1'b1;
					ok_q   <= 1'b1;
					if (func_q == FUNC_REMOVE_ALL && CW'(idx_q) < fill_dec) begin
						state_q <= ST_SCAN;
					end else begin
						state_q <= ST_DONE;
					end
				end
				ST_SCAN: state_q <= ST_CMP;
				ST_DONE: begin
					if (res_ready) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign res_valid   = (state_q == ST_DONE) && res_ready;
	assign res_success = ok_q;
	assign res_removed = gone_q;
	assign res_items   = fill_q;

endmodule

// ===== hdl/ubt_outreg.sv =====
// Output register for the unordered bag table result channel.
// Holds one result while the receiver stalls; frees when it is taken.
// Depends on ubt_pkg.
module ubt_outreg import ubt_pkg::*; #(
	parameter int CW = $clog2(DEFAULT_CAPACITY + 1)
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          res_valid,
	output logic          res_ready,
	input  logic          res_success,
	input  logic [CW-1:0] res_removed,
	input  logic [CW-1:0] res_items,
	output logic          out_valid,
	input  logic          out_stall,
	output logic          success,
	output logic [CW-1:0] removed_count,
	output logic [CW-1:0] item_count
);

	logic          valid_q;
	logic          success_q;
	logic [CW-1:0] removed_q;
	logic [CW-1:0] items_q;

	assign res_ready = !valid_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (res_ready) begin
			valid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid) begin
			success_q <= res_success;
			removed_q <= res_removed;
			items_q   <= res_items;
		end
	end

	assign out_valid     = valid_q;
	assign success       = success_q;
	assign removed_count = removed_q;
	assign item_count    = items_q;

endmodule

// ===== hdl/unordered_bag_table_top.sv =====
// Unordered bag table: fixed-capacity bag of 32-bit values with swap-remove.
// Input channel in_valid/in_stall carries func and value; one result per request
// leaves on out_valid/out_stall as success, removed_count and item_count.
// An add goes from accept straight to the done state, then into the result
// register. A removal compares the held entries through the single entry
// memory, one entry per cycle; each match passes through a move state that
// writes the last entry into its slot and, for remove-all, a scan state that
// rereads the refilled slot. The next request can be accepted in the cycle
// after the result is loaded.
// One request is in work at a time; in_stall is high while it is in work.
// The output register holds a finished result while out_stall is high,
// and the next request is accepted meanwhile; its result waits until the
// register frees.
// Reset clears the entry count and all handshake state at once; entry
// contents are not cleared, and no clearing pass is needed.
// Depends on ubt_pkg, ubt_engine and ubt_outreg.
module unordered_bag_table_top import ubt_pkg::*; #(
	parameter int CAPACITY = DEFAULT_CAPACITY,
	parameter int CW = $clog2(CAPACITY + 1)
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	output logic                     in_stall,
	input  logic [FUNC_W-1:0]        func,
	input  logic signed [DATA_W-1:0] value,
	output logic                     out_valid,
	input  logic                     out_stall,
	output logic                     success,
	output logic [CW-1:0]            removed_count,
	output logic [CW-1:0]            item_count
);

	logic          res_valid;
	logic          res_ready;
	logic          res_success;
	logic [CW-1:0] res_removed;
	logic [CW-1:0] res_items;

	ubt_engine #(
		.CAPACITY(CAPACITY),
		.CW(CW)
	) u_engine (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(in_valid),
		.req_stall(in_stall),
		.req_func(func),
		.req_value(value),
		.res_valid(res_valid),
		.res_ready(res_ready),
		.res_success(res_success),
		.res_removed(res_removed),
		.res_items(res_items)
	);

	ubt_outreg #(
		.CW(CW)
	) u_outreg (
		.clk(clk),
		.arst_n(arst_n),
		.res_valid(res_valid),
		.res_ready(res_ready),
		.res_success(res_success),
		.res_removed(res_removed),
		.res_items(res_items),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.success(success),
		.removed_count(removed_count),
		.item_count(item_count)
	);

endmodule

// ===== bench/tb_top.sv =====
// Testbench for unordered_bag_table_top: directed and random add and remove requests
// under varying sender idling and receiver stalls, checked against a bag model.
// Depends on ubt_pkg and the unordered_bag_table_top RTL.
`timescale 1ns / 100ps

module tb_top;
	import ubt_pkg::*;

	localparam int CAPACITY = DEFAULT_CAPACITY;
	localparam int CW = $clog2(CAPACITY + 1);
	localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;
	localparam int CYCLE_LIMIT = 1000000;
	localparam int PHASE_ITEMS = 306;

	class bag_scoreboard;
		typedef struct {
			logic          success;
			logic [CW-1:0] removed_count;
			logic [CW-1:0] item_count;
		} bag_result_t;

		logic [DATA_W-1:0] slots[CAPACITY];
		int unsigned       held;
		bag_result_t       expected_q[$];
		int                errors;

		function new();
			held = 0;
			errors = 0;
		endfunction

		function bit drop_first(logic [DATA_W-1:0] v);
			for (int i = 0; i < held; i++) begin
				if (slots[i] == v) begin
					slots[i] = slots[held - 1];
					held--;
					return 1'b1;
				end
			end
			return 1'b0;
		endfunction

		function void note_request(logic [FUNC_W-1:0] f, logic [DATA_W-1:0] v);
			bag_result_t res;
			int unsigned gone;
			gone = 0;
			res.success = 1'b0;
			case (f)
				FUNC_ADD: begin
					if (held < CAPACITY) begin
						slots[held] = v;
						held++;
						res.success = 1'b1;
					end
				end
				FUNC_REMOVE_ONE: begin
					if (drop_first(v)) begin
						gone = 1;
						res.success = 1'b1;
					end
				end
				FUNC_REMOVE_ALL: begin
					while (drop_first(v))
						gone++;
					res.success = (gone != 0);
				end
				default: ;
			endcase
			res.removed_count = gone[CW-1:0];
			res.item_count = held[CW-1:0];
			expected_q.push_back(res);
		endfunction

		function void check_result(logic s, logic [CW-1:0] rc, logic [CW-1:0] ic);
			bag_result_t exp_res;
			if (expected_q.size() == 0) begin
				$error("result with no request waiting: success %0d removed_count %0d item_count %0d",
					s, rc, ic);
				errors++;
				return;
			end
			exp_res = expected_q.pop_front();
			if (s !== exp_res.success) begin
				$error("success: expected %0d, actual %0d", exp_res.success, s);
				errors++;
			end
			if (rc !== exp_res.removed_count) begin
				$error("removed_count: expected %0d, actual %0d", exp_res.removed_count, rc);
				errors++;
			end
			if (ic !== exp_res.item_count) begin
				$error("item_count: expected %0d, actual %0d", exp_res.item_count, ic);
				errors++;
			end
		endfunction
	endclass

	logic                     clk;
	logic                     arst_n;
	logic                     in_valid;
	logic                     in_stall;
	logic [FUNC_W-1:0]        func;
	logic signed [DATA_W-1:0] value;
	logic                     out_valid;
	logic                     out_stall;
	logic                     success;
	logic [CW-1:0]            removed_count;
	logic [CW-1:0]            item_count;

	bag_scoreboard sb;
	int            idle_pct;
	int            stall_pct;
	int            cycles;

	unordered_bag_table_top #(
		.CAPACITY(CAPACITY)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.func(func),
		.value(value),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.success(success),
		.removed_count(removed_count),
		.item_count(item_count)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	always @(negedge clk) begin
		out_stall <= ($urandom_range(99) < stall_pct);
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			sb.check_result(success, removed_count, item_count);
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles == CYCLE_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end
	end

	function automatic logic [DATA_W-1:0] fresh_value();
		logic [DATA_W-1:0] v;
		case ($urandom_range(5))
			0: v = 32'h8000_0000 | $urandom_range(15);
			1: v = 32'hFFFF_FFFF - $urandom_range(15);
			2: v = $urandom_range(15);
			default: v = $urandom;
		endcase
		return v;
	endfunction

	task automatic send_request(input logic [FUNC_W-1:0] f, input logic [DATA_W-1:0] v);
		while ($urandom_range(99) < idle_pct) begin
			@(negedge clk);
			in_valid <= 1'b0;
		end
		@(negedge clk);
		in_valid <= 1'b1;
		func <= f;
		value <= v;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		sb.note_request(f, v);
	endtask

	task automatic wait_for_results();
		@(negedge clk);
		in_valid <= 1'b0;
		while (sb.expected_q.size() != 0)
			@(negedge clk);
	endtask

	task automatic run_directed();
		send_request(FUNC_REMOVE_ONE, 32'h0000_0000);
		send_request(FUNC_REMOVE_ALL, 32'hFFFF_FFFF);
		send_request(FUNC_UNUSED, 32'h1234_5678);
		send_request(FUNC_ADD, 32'h8000_0000);
		send_request(FUNC_ADD, 32'h7FFF_FFFF);
		send_request(FUNC_ADD, 32'h0000_0000);
		send_request(FUNC_ADD, 32'hFFFF_FFFF);
		send_request(FUNC_ADD, 32'h0000_0001);
		send_request(FUNC_REMOVE_ONE, 32'h0000_0000);
		send_request(FUNC_REMOVE_ALL, 32'h7FFF_FFFF);
		repeat (CAPACITY - 3)
			send_request(FUNC_ADD, 32'hA5A5_A5A5);
		send_request(FUNC_ADD, 32'h0000_0001);
		send_request(FUNC_UNUSED, 32'hA5A5_A5A5);
		send_request(FUNC_REMOVE_ALL, 32'hA5A5_A5A5);
		send_request(FUNC_REMOVE_ONE, 32'h1234_5678);
	endtask

	task automatic run_random(input int n_items);
		logic [DATA_W-1:0] pool[3];
		logic [FUNC_W-1:0] f;
		logic [DATA_W-1:0] v;
		int                npool;
		int                sent;
		int                len;
		int                add_pct;
		int                r;
		int                k;
		sent = 0;
		while (sent < n_items) begin
			npool = $urandom_range(3, 1);
			for (k = 0; k < 3; k++)
				pool[k] = fresh_value();
			if ($urandom_range(9) == 0) begin
				// fill up, then sweep every pool value out
				while (sb.held < CAPACITY) begin
					send_request(FUNC_ADD, pool[$urandom_range(npool - 1)]);
					sent++;
				end
				for (k = 0; k < npool; k++) begin
					send_request(FUNC_REMOVE_ALL, pool[k]);
					sent++;
				end
			end else begin
				len = $urandom_range(20, 6);
				repeat (len) begin
					if (sb.held < 4)
						add_pct = 70;
					else if (sb.held >= CAPACITY - 2)
						add_pct = 25;
					else
						add_pct = 45;
					r = $urandom_range(99);
					if (r < 3)
						f = FUNC_UNUSED;
					else if (r < 3 + add_pct)
						f = FUNC_ADD;
					else if ($urandom_range(99) < 60)
						f = FUNC_REMOVE_ONE;
					else
						f = FUNC_REMOVE_ALL;
					if (f == FUNC_ADD)
						v = ($urandom_range(99) < 85) ? pool[$urandom_range(npool - 1)]
							: fresh_value();
					else if (sb.held > 0 && $urandom_range(99) < 70)
						v = sb.slots[$urandom_range(sb.held - 1)];
					else if ($urandom_range(1) == 0)
						v = pool[$urandom_range(npool - 1)];
					else
						v = fresh_value();
					send_request(f, v);
					sent++;
				end
			end
		end
	endtask

	initial begin
		sb = new();
		cycles = 0;
		idle_pct = 0;
		stall_pct = 0;
		arst_n = 1'b0;
		in_valid = 1'b0;
		func = FUNC_ADD;
		value = '0;
		out_stall = 1'b0;
		repeat (7)
			@(negedge clk);
		arst_n = 1'b1;

		run_directed();
		for (int phase = 0; phase < 4; phase++) begin
			case (phase)
				0: begin
					idle_pct = 0;
					stall_pct = 0;
				end
				1: begin
					idle_pct = 47;
					stall_pct = 0;
				end
				2: begin
					idle_pct = 0;
					stall_pct = 47;
				end
				default: begin
					idle_pct = 33;
					stall_pct = 33;
				end
			endcase
			run_random(PHASE_ITEMS / 2);
			wait_for_results();
			run_random(PHASE_ITEMS / 2);
		end

		@(negedge clk);
		in_valid <= 1'b0;
		stall_pct = 0;
		while (sb.expected_q.size() != 0)
			@(posedge clk);
		repeat (80)
			@(posedge clk);
		if (sb.errors == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule

// ===== files.f =====
hdl/ubt_pkg.sv
hdl/ubt_engine.sv
hdl/ubt_outreg.sv
hdl/unordered_bag_table_top.sv
bench/tb_top.sv
